FILE: hw/rtl/union_find_engine_assert.svh
// Assertion macros shared by the union-find engine checker.
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define UFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("union_find_engine: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define UFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("union_find_engine: same-cycle check failed");

`endif

FILE: hw/rtl/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared constants, types and helpers for the union-find engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

	localparam int NODES   = 1024;
	localparam int NODE_W  = 10;
	localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int ENTRY_W = IDX_W + 1;
	localparam int CMP_W   = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [NODE_W-1:0]  node_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_A,
		S_LINK_A,
		S_START_B,
		S_WALK_B,
		S_LINK_B,
		S_FINISH
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic clr_wr;   // write a root entry at the sweep counter
		logic load_in;  // capture an input item, read node a
		logic load_b;   // start the second find, read node b
		logic examine;  // look at the read data of the walk
		logic step;     // follow the link, read the next entry
		logic save_a;   // keep the current root as root of a
		logic link_wr;  // point the start node at the root
		logic union_wr; // hang root of b under root of a
		logic out_load; // load the query result
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic rd_root;
		logic start_root;
		logic kind;
		logic roots_eq;
		logic out_free;
	} status_t;

	function automatic idx_t clamp_node(node_t v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (w >= CMP_W'(NODES))
			w = CMP_W'(NODES - 1);
		return w[IDX_W-1:0];
	endfunction

	function automatic entry_t root_entry();
		return {1'b1, {IDX_W{1'b0}}};
	endfunction

	function automatic entry_t link_entry(idx_t p);
		return {1'b0, p};
	endfunction

endpackage

FILE: hw/rtl/union_find_engine.sv
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set union / same-set query over a parent table with one-level
// path compression.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir | meaning
//  --------+----------------------------------+-----+---------------------------
//  in      | in_valid in_stall kind node_a/b  | in  | union (0) or query (1)
//  out     | out_valid out_stall same_set     | out | one transfer per query
//
// No new item is taken until the current one is through; da and db are the
// link counts from node a and node b to their roots, and every link is one
// read of the parent table memory, which has separate read and write ports.
// After reset a clearing pass writes all NODES (1024) entries, one a cycle,
// and in_stall stays high throughout that pass.
// A waiting query result sits in the output register; the engine goes on with
// the next item; a query's last step waits only while a result is stalled.
module union_find_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           kind,
	input  ufe_pkg::node_t node_a,
	input  ufe_pkg::node_t node_b,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           same_set
);
	import ufe_pkg::*;

	cmd_t    cmd;
	status_t st;

	ufe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ufe_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.kind      (kind),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.same_set  (same_set)
	);

endmodule

FILE: hw/rtl/ufe_ctrl.sv
// ----------------------------------------------------------------------------
// ufe_ctrl
// Sequencer for the table sweep, the two finds and the final update.
// ----------------------------------------------------------------------------
module ufe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ufe_pkg::status_t st,
	output ufe_pkg::cmd_t    cmd
);
	import ufe_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_nxt;
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last)
					state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_WALK_A;
				end
			end
			S_WALK_A: begin
				cmd.examine = 1'b1;
				if (st.rd_root)
					state_nxt = S_LINK_A;
				else
					cmd.step = 1'b1;
			end
			S_LINK_A: begin
				cmd.save_a  = 1'b1;
				cmd.link_wr = !st.start_root;
				state_nxt   = S_START_B;
			end
			S_START_B: begin
				cmd.load_b = 1'b1;
				state_nxt  = S_WALK_B;
			end
			S_WALK_B: begin
				cmd.examine = 1'b1;
				if (st.rd_root)
					state_nxt = S_LINK_B;
				else
					cmd.step = 1'b1;
			end
			S_LINK_B: begin
				cmd.link_wr = !st.start_root;
				state_nxt   = S_FINISH;
			end
			S_FINISH: begin
				if (!st.kind) begin
					cmd.union_wr = !st.roots_eq;
					state_nxt    = S_IDLE;
				end else if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

endmodule

FILE: hw/rtl/ufe_datapath.sv
// ----------------------------------------------------------------------------
// ufe_datapath
// Parent table memory, walk registers and result register.
// ----------------------------------------------------------------------------
module ufe_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ufe_pkg::cmd_t    cmd,
	output ufe_pkg::status_t st,
	input  logic             kind,
	input  ufe_pkg::node_t   node_a,
	input  ufe_pkg::node_t   node_b,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             same_set
);
	import ufe_pkg::*;

	entry_t mem [NODES];

	entry_t rdata_q;
	idx_t   clr_cnt_q;
	idx_t   cur_q, start_q, root_a_q, node_b_q;
	logic   kind_q, first_q, start_root_q;
	logic   out_valid_q, same_set_q;

	idx_t   rd_addr, wr_addr;
	entry_t wr_data;
	logic   rd_en, wr_en;

	// read port
	always_comb begin
		rd_en = cmd.load_in | cmd.load_b | cmd.step;
		if (cmd.load_in)
			rd_addr = clamp_node(node_a);
		else if (cmd.load_b)
			rd_addr = node_b_q;
		else
			rd_addr = rdata_q[IDX_W-1:0];
	end

	// write port
	always_comb begin
		wr_en = cmd.clr_wr | cmd.link_wr | cmd.union_wr;
		if (cmd.clr_wr) begin
			wr_addr = clr_cnt_q;
			wr_data = root_entry();
		end else if (cmd.link_wr) begin
			wr_addr = start_q;
			wr_data = link_entry(cur_q);
		end else begin
			wr_addr = cur_q;
			wr_data = link_entry(root_a_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_wr)
			clr_cnt_q <= clr_cnt_q + idx_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			first_q <= 1'b0;
		else if (cmd.load_in || cmd.load_b)
			first_q <= 1'b1;
		else if (cmd.examine)
			first_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q   <= kind;
			node_b_q <= clamp_node(node_b);
			cur_q    <= clamp_node(node_a);
			start_q  <= clamp_node(node_a);
		end else if (cmd.load_b) begin
			cur_q   <= node_b_q;
			start_q <= node_b_q;
		end else if (cmd.step) begin
			cur_q <= rdata_q[IDX_W-1:0];
		end
		if (cmd.examine && first_q)
			start_root_q <= rdata_q[IDX_W];
		if (cmd.save_a)
			root_a_q <= cur_q;
	end

	// result register, frees the controller while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			same_set_q <= (root_a_q == cur_q);
	end

	assign out_valid = out_valid_q;
	assign same_set  = same_set_q;

	always_comb begin
		st.clr_last   = (clr_cnt_q == idx_t'(NODES - 1));
		st.rd_root    = rdata_q[IDX_W];
		st.start_root = start_root_q;
		st.kind       = kind_q;
		st.roots_eq   = (root_a_q == cur_q);
		st.out_free   = !out_valid_q || !out_stall;
	end

endmodule

FILE: hw/rtl/ufe_checker.sv
// ----------------------------------------------------------------------------
// ufe_checker
// Port-level checks for the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "union_find_engine_assert.svh"

module ufe_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           kind,
	input ufe_pkg::node_t node_a,
	input ufe_pkg::node_t node_b,
	input logic           out_valid,
	input logic           out_stall,
	input logic           same_set
);
	import ufe_pkg::*;

	logic                  in_xfer;
	logic [2*NODE_W:0]     in_word;
	assign in_xfer = in_valid && !in_stall;
	assign in_word = {kind, node_a, node_b};

	// a stalled input transfer stays put
	`UFE_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_word))

	// a stalled result stays put
	`UFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`UFE_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(same_set))

	// a union never raises a result in the cycle after its transfer
	`UFE_ASSERT_NEXT(a_union_quiet, clk, arst_n, in_xfer && !kind && !out_valid, !out_valid && in_stall)

	// a result is loaded only from the last step, while input is held off
	`UFE_ASSERT_NOW(a_result_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind union_find_engine ufe_checker u_ufe_checker (.*);
